// File: rtl/lts_pkg.sv
// shared types, character codes and result helpers for the line token splitter
`default_nettype none

package lts_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [15:0] MAX_LINE_LENGTH_RST = 16'd4096;
  localparam logic [13:0] MAX_TOKENS_RST      = 14'd16000;

  localparam logic REG_MAX_LINE_LENGTH = 1'b0;
  localparam logic REG_MAX_TOKENS      = 1'b1;

  localparam logic [1:0] KIND_TOKEN  = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_EOF        = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_UNMATCHED  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_TOO_MANY   = 3'd4;

  typedef enum logic [3:0] {
    MODE_BETWEEN  = 4'b0001,
    MODE_PLAIN    = 4'b0010,
    MODE_QUOTED   = 4'b0100,
    MODE_AFTER_CR = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [13:0] token_number;
    logic        was_quoted;
    logic [31:0] line_number;
    logic [2:0]  status;
    logic        last;
  } lts_result_t;

  function automatic lts_result_t make_status(input logic [31:0] line,
                                              input logic [2:0] status);
    lts_result_t r;
    r             = '0;
    r.kind        = KIND_STATUS;
    r.line_number = line;
    r.status      = status;
    return r;
  endfunction

  function automatic lts_result_t make_line_end(input logic [31:0] line,
                                                input logic [13:0] count);
    lts_result_t r;
    r              = '0;
    r.kind         = KIND_LINE;
    r.line_number  = line;
    r.token_number = count;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/line_token_splitter.sv
// line token splitter: byte stream in, token, line end and status transactions out
// path: an accepted byte goes to the input register, through the scan step into the result queue, then out
// throughput: one byte per cycle while the queue has room for two results, set by the
//   combinational scan step between the input register and the four-entry result queue;
//   a byte ending a token and its line yields two transactions, sent one per unstalled cycle
// reset: synchronous active-low; clears state, restores register defaults, empties the queue
`default_nettype none

module line_token_splitter #(
  parameter int unsigned LINE_OFFSET_BITS = 16,
  parameter int unsigned TOKEN_COUNT_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_token_offset,
  output logic [15:0]      out_token_length,
  output logic [13:0]      out_token_number,
  output logic             out_was_quoted,
  output logic [31:0]      out_line_number,
  output logic [2:0]       out_status,
  output logic             out_last
);
  import lts_pkg::*;

  logic [15:0] max_len_r;
  logic [13:0] max_tok_r;

  logic        in_v_r;
  logic        in_v_nxt;
  logic [7:0]  in_byte_r;
  logic        in_eoi_r;
  logic        in_acc;
  logic        proc;

  logic                        stopped_r;
  logic                        stopped_nxt;
  scan_mode_t                  mode_r;
  scan_mode_t                  mode_nxt;
  logic [7:0]                  prev_r;
  logic [7:0]                  prev_nxt;
  logic [LINE_OFFSET_BITS-1:0] line_off_r;
  logic [LINE_OFFSET_BITS-1:0] line_off_nxt;
  logic [LINE_OFFSET_BITS-1:0] tok_start_r;
  logic [LINE_OFFSET_BITS-1:0] tok_start_nxt;
  logic [TOKEN_COUNT_BITS-1:0] tok_cnt_r;
  logic [TOKEN_COUNT_BITS-1:0] tok_cnt_nxt;
  logic [31:0]                 line_cnt_r;
  logic [31:0]                 line_cnt_nxt;

  logic [1:0]  n_res;
  lts_result_t res0;
  lts_result_t res1;

  lts_result_t fifo_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  wr_ptr_nxt;
  logic [1:0]  rd_ptr_r;
  logic [1:0]  rd_ptr_nxt;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [1:0]  push;
  logic        pop;
  lts_result_t head;

  // room for two results regardless of the output side
  assign proc     = in_v_r && (cnt_r <= 3'd2);
  assign in_stall = in_v_r && !proc;
  assign in_acc   = in_valid && !in_stall;
  assign in_v_nxt = in_acc ? 1'b1 : (proc ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LINE_LENGTH_RST;
      max_tok_r <= MAX_TOKENS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MAX_LINE_LENGTH: max_len_r <= cfg_wdata;
        REG_MAX_TOKENS:      max_tok_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
      in_eoi_r  <= in_end_of_input;
    end
  end

  lts_scan #(
    .LINE_OFFSET_BITS(LINE_OFFSET_BITS),
    .TOKEN_COUNT_BITS(TOKEN_COUNT_BITS)
  ) u_scan (
    .stopped_i   (stopped_r),
    .mode_i      (mode_r),
    .prev_i      (prev_r),
    .line_off_i  (line_off_r),
    .tok_start_i (tok_start_r),
    .tok_cnt_i   (tok_cnt_r),
    .line_cnt_i  (line_cnt_r),
    .max_len_i   (max_len_r),
    .max_tok_i   (max_tok_r),
    .byte_i      (in_byte_r),
    .eoi_i       (in_eoi_r),
    .stopped_o   (stopped_nxt),
    .mode_o      (mode_nxt),
    .prev_o      (prev_nxt),
    .line_off_o  (line_off_nxt),
    .tok_start_o (tok_start_nxt),
    .tok_cnt_o   (tok_cnt_nxt),
    .line_cnt_o  (line_cnt_nxt),
    .n_o         (n_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r   <= 1'b0;
      mode_r      <= MODE_BETWEEN;
      prev_r      <= '0;
      line_off_r  <= '0;
      tok_start_r <= '0;
      tok_cnt_r   <= '0;
      line_cnt_r  <= 32'd1;
    end else if (proc) begin
      stopped_r   <= stopped_nxt;
      mode_r      <= mode_nxt;
      prev_r      <= prev_nxt;
      line_off_r  <= line_off_nxt;
      tok_start_r <= tok_start_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
      line_cnt_r  <= line_cnt_nxt;
    end
  end

  // result queue
  assign push       = proc ? n_res : 2'd0;
  assign pop        = (cnt_r != 3'd0) && !out_stall;
  assign wr_ptr_nxt = wr_ptr_r + push;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  assign head             = fifo_r[rd_ptr_r];
  assign out_valid        = (cnt_r != 3'd0);
  assign out_kind         = head.kind;
  assign out_token_offset = head.token_offset;
  assign out_token_length = head.token_length;
  assign out_token_number = head.token_number;
  assign out_was_quoted   = head.was_quoted;
  assign out_line_number  = head.line_number;
  assign out_status       = head.status;
  assign out_last         = head.last;

endmodule

`default_nettype wire

// File: rtl/lts_scan.sv
// per-byte scan step: next tokenizer state and up to two results
`default_nettype none

module lts_scan #(
  parameter int unsigned LINE_OFFSET_BITS = 16,
  parameter int unsigned TOKEN_COUNT_BITS = 14
) (
  input  wire logic                        stopped_i,
  input  lts_pkg::scan_mode_t              mode_i,
  input  wire logic [7:0]                  prev_i,
  input  wire logic [LINE_OFFSET_BITS-1:0] line_off_i,
  input  wire logic [LINE_OFFSET_BITS-1:0] tok_start_i,
  input  wire logic [TOKEN_COUNT_BITS-1:0] tok_cnt_i,
  input  wire logic [31:0]                 line_cnt_i,
  input  wire logic [15:0]                 max_len_i,
  input  wire logic [13:0]                 max_tok_i,
  input  wire logic [7:0]                  byte_i,
  input  wire logic                        eoi_i,
  output logic                             stopped_o,
  output lts_pkg::scan_mode_t              mode_o,
  output logic [7:0]                       prev_o,
  output logic [LINE_OFFSET_BITS-1:0]      line_off_o,
  output logic [LINE_OFFSET_BITS-1:0]      tok_start_o,
  output logic [TOKEN_COUNT_BITS-1:0]      tok_cnt_o,
  output logic [31:0]                      line_cnt_o,
  output logic [1:0]                       n_o,
  output lts_pkg::lts_result_t             res0_o,
  output lts_pkg::lts_result_t             res1_o
);
  import lts_pkg::*;

  localparam int unsigned CW = (LINE_OFFSET_BITS > 16) ? LINE_OFFSET_BITS : 16;
  localparam int unsigned TW = (TOKEN_COUNT_BITS > 14) ? TOKEN_COUNT_BITS : 14;

  logic [LINE_OFFSET_BITS-1:0] tok_len;
  logic [CW-1:0]               tok_start_ext;
  logic [CW-1:0]               tok_len_ext;
  logic [TOKEN_COUNT_BITS-1:0] tok_cnt_inc;
  logic [TW-1:0]               tok_cnt_ext;
  logic [TW-1:0]               tok_inc_ext;
  logic                        tok_full;
  logic                        len_full;
  logic                        is_term;
  logic                        is_sep;
  logic                        at_start;
  scan_mode_t                  mode_e;
  lts_result_t                 tok_res;

  assign tok_len       = line_off_i - tok_start_i;
  assign tok_start_ext = CW'(tok_start_i);
  assign tok_len_ext   = CW'(tok_len);
  assign tok_cnt_inc   = tok_cnt_i + 1'b1;
  assign tok_cnt_ext   = TW'(tok_cnt_i);
  assign tok_inc_ext   = TW'(tok_cnt_inc);
  assign tok_full      = (tok_cnt_ext >= TW'(max_tok_i)) || (&tok_cnt_i);
  assign len_full      = (CW'(line_off_i) >= CW'(max_len_i)) || (&line_off_i);
  assign is_term       = (byte_i == CH_CR) || (byte_i == CH_LF);
  assign is_sep        = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign mode_e        = (mode_i == MODE_AFTER_CR) ? MODE_BETWEEN : mode_i;
  assign at_start      = (mode_i == MODE_AFTER_CR) ||
                         ((mode_i == MODE_BETWEEN) && (line_off_i == '0));

  always_comb begin
    tok_res              = '0;
    tok_res.kind         = KIND_TOKEN;
    tok_res.token_offset = tok_start_ext[15:0];
    tok_res.token_length = tok_len_ext[15:0];
    tok_res.token_number = tok_cnt_ext[13:0];
    tok_res.was_quoted   = (mode_e == MODE_QUOTED);
    tok_res.line_number  = line_cnt_i;
  end

  always_comb begin
    stopped_o   = stopped_i;
    mode_o      = mode_i;
    prev_o      = prev_i;
    line_off_o  = line_off_i;
    tok_start_o = tok_start_i;
    tok_cnt_o   = tok_cnt_i;
    line_cnt_o  = line_cnt_i;
    n_o         = 2'd0;
    res0_o      = '0;
    res1_o      = '0;
    if (!stopped_i) begin
      if (eoi_i) begin
        res0_o    = make_status(line_cnt_i, at_start ? ST_EOF : ST_INCOMPLETE);
        n_o       = 2'd1;
        stopped_o = 1'b1;
      end else if ((mode_i == MODE_AFTER_CR) && (byte_i == CH_LF)) begin
        mode_o = MODE_BETWEEN;
        prev_o = byte_i;
      end else if (is_term) begin
        if (mode_e == MODE_QUOTED) begin
          res0_o    = make_status(line_cnt_i, ST_UNMATCHED);
          n_o       = 2'd1;
          stopped_o = 1'b1;
        end else if ((mode_e == MODE_PLAIN) && tok_full) begin
          res0_o    = make_status(line_cnt_i, ST_TOO_MANY);
          n_o       = 2'd1;
          stopped_o = 1'b1;
        end else begin
          if (mode_e == MODE_PLAIN) begin
            res0_o = tok_res;
            res1_o = make_line_end(line_cnt_i, tok_inc_ext[13:0]);
            n_o    = 2'd2;
          end else begin
            res0_o = make_line_end(line_cnt_i, tok_cnt_ext[13:0]);
            n_o    = 2'd1;
          end
          line_cnt_o  = line_cnt_i + 32'd1;
          line_off_o  = '0;
          tok_start_o = '0;
          tok_cnt_o   = '0;
          mode_o      = (byte_i == CH_CR) ? MODE_AFTER_CR : MODE_BETWEEN;
          prev_o      = byte_i;
        end
      end else if (len_full) begin
        res0_o    = make_status(line_cnt_i, ST_TOO_LONG);
        n_o       = 2'd1;
        stopped_o = 1'b1;
      end else begin
        line_off_o = line_off_i + 1'b1;
        prev_o     = byte_i;
        mode_o     = mode_e;
        case (mode_e)
          MODE_BETWEEN: begin
            if (byte_i == CH_QUOTE) begin
              mode_o      = MODE_QUOTED;
              tok_start_o = line_off_i + 1'b1;
            end else if (!is_sep) begin
              mode_o      = MODE_PLAIN;
              tok_start_o = line_off_i;
            end
          end
          MODE_PLAIN: begin
            if (is_sep) begin
              if (tok_full) begin
                res0_o    = make_status(line_cnt_i, ST_TOO_MANY);
                stopped_o = 1'b1;
              end else begin
                res0_o    = tok_res;
                tok_cnt_o = tok_cnt_inc;
                mode_o    = MODE_BETWEEN;
              end
              n_o = 2'd1;
            end
          end
          MODE_QUOTED: begin
            if ((byte_i == CH_QUOTE) && (prev_i != CH_BSLASH)) begin
              if (tok_full) begin
                res0_o    = make_status(line_cnt_i, ST_TOO_MANY);
                stopped_o = 1'b1;
              end else begin
                res0_o    = tok_res;
                tok_cnt_o = tok_cnt_inc;
                mode_o    = MODE_BETWEEN;
              end
              n_o = 2'd1;
            end
          end
          default: begin
            mode_o = MODE_BETWEEN;
          end
        endcase
      end
    end
    res0_o.last = (n_o == 2'd1);
    res1_o.last = (n_o == 2'd2);
  end

endmodule

`default_nettype wire

// File: rtl/lts_checker.sv
// port-level checks for the line token splitter, bound to the top level
`default_nettype none

module lts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [15:0] out_token_offset,
  input wire logic [15:0] out_token_length,
  input wire logic [13:0] out_token_number,
  input wire logic        out_was_quoted,
  input wire logic [31:0] out_line_number,
  input wire logic [2:0]  out_status,
  input wire logic        out_last
);
  import lts_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_token_offset) && $stable(out_token_length) &&
      $stable(out_token_number) && $stable(out_line_number) && $stable(out_status))
    else $error("result changed while stalled");

  // a final status closes its item and nothing follows it
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STATUS) |-> out_last)
    else $error("status transaction not last");

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_STATUS) |=> !out_valid)
    else $error("transaction after final status");

  // line end carries only the count and the line number
  a_line_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_LINE) |->
      (out_token_offset == 16'd0) && (out_token_length == 16'd0) &&
      !out_was_quoted && (out_status == ST_EOF) && out_last)
    else $error("bad line end transaction");

  // a line end always closes its item, so a transaction right after one is on the next line
  a_line_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_LINE) ##1 out_valid |->
      out_line_number == $past(out_line_number) + 32'd1)
    else $error("line number did not advance");

endmodule

bind line_token_splitter lts_checker u_lts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_token_offset (out_token_offset),
  .out_token_length (out_token_length),
  .out_token_number (out_token_number),
  .out_was_quoted   (out_was_quoted),
  .out_line_number  (out_line_number),
  .out_status       (out_status),
  .out_last         (out_last)
);

`default_nettype wire

// File: verif/line_token_splitter_tb.sv
// self-checking testbench for the line token splitter: directed table, then random lines, then one final ending
`timescale 1ns / 100ps

module line_token_splitter_tb;
  import lts_pkg::*;

  localparam logic [2:0] NO_STATUS = 3'd0;
  localparam lts_result_t NO_RESULT = '0;

  typedef struct {
    scan_mode_t  mode;
    logic [7:0]  prev;
    logic [15:0] off;
    logic [15:0] tok_start;
    logic [13:0] ntok;
    logic [31:0] line;
    logic        halted;
    logic [15:0] lim_len;
    logic [13:0] lim_tok;
  } splitter_state_t;

  typedef struct {
    logic [7:0]  b;
    logic        eoi;
    bit          typed;
    int          n;
    lts_result_t r0;
    lts_result_t r1;
  } stim_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [15:0] out_token_offset;
  logic [15:0] out_token_length;
  logic [13:0] out_token_number;
  logic        out_was_quoted;
  logic [31:0] out_line_number;
  logic [2:0]  out_status;
  logic        out_last;

  splitter_state_t model;
  lts_result_t     pending_results[$];
  stim_row_t       dir_rows[$];
  logic [7:0]      line_q[$];
  int              mismatches = 0;
  int              burst_left = 0;
  stall_mode_t     stall_mode = STALL_NONE;
  int              stall_run = 0;

  line_token_splitter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_token_number (out_token_number),
    .out_was_quoted   (out_was_quoted),
    .out_line_number  (out_line_number),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #2 clk = ~clk;

  function automatic lts_result_t mk_result(input logic [1:0] kind, input logic [15:0] off,
                                            input logic [15:0] len, input logic [13:0] num,
                                            input logic quoted, input logic [31:0] line,
                                            input logic [2:0] status, input logic last);
    lts_result_t r;
    r.kind         = kind;
    r.token_offset = off;
    r.token_length = len;
    r.token_number = num;
    r.was_quoted   = quoted;
    r.line_number  = line;
    r.status       = status;
    r.last         = last;
    return r;
  endfunction

  function automatic lts_result_t token_result(input splitter_state_t s,
                                               input logic [15:0] end_pos, input logic quoted);
    return mk_result(KIND_TOKEN, s.tok_start, end_pos - s.tok_start, s.ntok, quoted, s.line,
                     NO_STATUS, 1'b0);
  endfunction

  // advances the splitter state by one byte and returns the transactions it causes
  function automatic int split_byte(inout splitter_state_t s, input logic [7:0] b,
                                    input logic eoi, output lts_result_t r0,
                                    output lts_result_t r1);
    lts_result_t got [2];
    int          n;
    logic [15:0] pos;
    logic [2:0]  code;
    logic        sep;
    logic        full;
    logic        stopping;
    logic        swallow;
    n        = 0;
    got[0]   = NO_RESULT;
    got[1]   = NO_RESULT;
    r0       = NO_RESULT;
    r1       = NO_RESULT;
    stopping = 1'b0;
    code     = NO_STATUS;
    if (s.halted)
      return 0;
    full = (s.ntok >= s.lim_tok) || (&s.ntok);
    if (eoi) begin
      stopping = 1'b1;
      code = (s.mode == MODE_AFTER_CR || (s.mode == MODE_BETWEEN && s.off == 0)) ?
             ST_EOF : ST_INCOMPLETE;
    end else begin
      swallow = 1'b0;
      if (s.mode == MODE_AFTER_CR) begin
        s.mode  = MODE_BETWEEN;
        swallow = (b == CH_LF);
      end
      if (swallow) begin
        n = 0;
      end else if (b == CH_CR || b == CH_LF) begin
        if (s.mode == MODE_QUOTED) begin
          stopping = 1'b1;
          code = ST_UNMATCHED;
        end else if (s.mode == MODE_PLAIN && full) begin
          stopping = 1'b1;
          code = ST_TOO_MANY;
        end else begin
          if (s.mode == MODE_PLAIN) begin
            got[n] = token_result(s, s.off, 1'b0);
            n++;
            s.ntok++;
          end
          got[n] = mk_result(KIND_LINE, '0, '0, s.ntok, 1'b0, s.line, NO_STATUS, 1'b0);
          n++;
          s.line++;
          s.off       = '0;
          s.tok_start = '0;
          s.ntok      = '0;
          s.mode      = (b == CH_CR) ? MODE_AFTER_CR : MODE_BETWEEN;
        end
      end else if (s.off >= s.lim_len || &s.off) begin
        stopping = 1'b1;
        code = ST_TOO_LONG;
      end else begin
        pos = s.off;
        sep = (b == CH_SPACE || b == CH_TAB);
        s.off++;
        case (s.mode)
          MODE_BETWEEN: begin
            if (b == CH_QUOTE) begin
              s.mode      = MODE_QUOTED;
              s.tok_start = pos + 16'd1;
            end else if (!sep) begin
              s.mode      = MODE_PLAIN;
              s.tok_start = pos;
            end
          end
          MODE_PLAIN: begin
            if (sep && full) begin
              stopping = 1'b1;
              code = ST_TOO_MANY;
            end else if (sep) begin
              got[n] = token_result(s, pos, 1'b0);
              n++;
              s.ntok++;
              s.mode = MODE_BETWEEN;
            end
          end
          default: begin
            if (b == CH_QUOTE && s.prev != CH_BSLASH) begin
              if (full) begin
                stopping = 1'b1;
                code = ST_TOO_MANY;
              end else begin
                got[n] = token_result(s, pos, 1'b1);
                n++;
                s.ntok++;
                s.mode = MODE_BETWEEN;
              end
            end
          end
        endcase
      end
      s.prev = b;
    end
    if (stopping) begin
      s.halted = 1'b1;
      got[0] = mk_result(KIND_STATUS, '0, '0, '0, 1'b0, s.line, code, 1'b0);
      n = 1;
    end
    if (n > 0)
      got[n - 1].last = 1'b1;
    r0 = got[0];
    r1 = got[1];
    return n;
  endfunction

  function automatic stim_row_t data_row(input logic [7:0] b, input logic eoi);
    stim_row_t r;
    r.b     = b;
    r.eoi   = eoi;
    r.typed = 1'b0;
    r.n     = 0;
    r.r0    = NO_RESULT;
    r.r1    = NO_RESULT;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input int n,
                                          input lts_result_t r0, input lts_result_t r1);
    stim_row_t r;
    r       = data_row(b, 1'b0);
    r.typed = 1'b1;
    r.n     = n;
    r.r0    = r0;
    r.r1    = r1;
    return r;
  endfunction

  // called and left at a falling edge
  task automatic send_item(input stim_row_t row);
    lts_result_t r0;
    lts_result_t r1;
    int          n;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid        = 1'b1;
    in_data_byte    = row.b;
    in_end_of_input = row.eoi;
    do @(posedge clk); while (in_stall);
    n = split_byte(model, row.b, row.eoi, r0, r1);
    if (row.typed) begin
      n  = row.n;
      r0 = row.r0;
      r1 = row.r1;
    end
    if (n > 0)
      pending_results.push_back(r0);
    if (n > 1)
      pending_results.push_back(r1);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_MAX_LINE_LENGTH)
      model.lim_len = val;
    else
      model.lim_tok = val[13:0];
  endtask

  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid = 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed lines within the current limits, some raw noise
  task automatic build_line();
    splitter_state_t trial;
    lts_result_t     d0;
    lts_result_t     d1;
    logic [7:0]      c;
    int              tries;
    int              ntok;
    int              k;
    int              j;
    int              len;
    bit              prev_quoted;
    for (tries = 0; tries < 20; tries++) begin
      line_q.delete();
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(0, 10);
        for (j = 0; j < len; j++)
          line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(CH_LF);
      end else begin
        ntok = $urandom_range(0, 5);
        prev_quoted = 1'b0;
        for (k = 0; k < ntok; k++) begin
          if ((k > 0 && !(prev_quoted && $urandom_range(0, 2) == 0)) ||
              $urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 2);
            for (j = 0; j < len; j++)
              line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end
          prev_quoted = $urandom_range(0, 2) == 0;
          if (prev_quoted) begin
            line_q.push_back(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (j = 0; j < len; j++) begin
              case ($urandom_range(0, 5))
                0: begin
                  line_q.push_back(CH_BSLASH);
                  line_q.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'("n"));
                end
                1: line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                default: begin
                  c = 8'($urandom_range(8'h21, 8'hFF));
                  if (c == CH_QUOTE || c == CH_BSLASH)
                    c = "q";
                  line_q.push_back(c);
                end
              endcase
            end
            line_q.push_back(CH_QUOTE);
          end else begin
            len = ($urandom_range(0, 59) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            for (j = 0; j < len; j++) begin
              c = 8'($urandom_range(8'h21, 8'hFF));
              if (j == 0 && c == CH_QUOTE)
                c = "p";
              line_q.push_back(c);
            end
          end
        end
        if ($urandom_range(0, 3) == 0)
          line_q.push_back(CH_TAB);
        case ($urandom_range(0, 2))
          0: line_q.push_back(CH_LF);
          1: line_q.push_back(CH_CR);
          default: begin
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
          end
        endcase
      end
      trial = model;
      foreach (line_q[k])
        void'(split_byte(trial, line_q[k], 1'b0, d0, d1));
      if (!trial.halted)
        break;
    end
    if (trial.halted) begin
      line_q.delete();
      line_q.push_back(CH_LF);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 40)
        $error("%s: expected %0d, actual %0d", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    lts_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $error("unexpected result transaction, kind %0d line %0d", out_kind, out_line_number);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("token_offset", 32'(want.token_offset), 32'(out_token_offset));
        check_field("token_length", 32'(want.token_length), 32'(out_token_length));
        check_field("token_number", 32'(want.token_number), 32'(out_token_number));
        check_field("was_quoted", 32'(want.was_quoted), 32'(out_was_quoted));
        check_field("line_number", want.line_number, out_line_number);
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(8, 80);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = (stall_run % 3 == 0);
    endcase
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [15:0] len_cfg;
    logic [13:0] tok_cfg;
    logic [2:0]  ending;
    int          phase;
    int          sent;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_addr        = REG_MAX_LINE_LENGTH;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_end_of_input = 1'b0;

    model.mode      = MODE_BETWEEN;
    model.prev      = '0;
    model.off       = '0;
    model.tok_start = '0;
    model.ntok      = '0;
    model.line      = 32'd1;
    model.halted    = 1'b0;
    model.lim_len   = MAX_LINE_LENGTH_RST;
    model.lim_tok   = MAX_TOKENS_RST;

    // plain, escaped quote, adjacent tokens, quote in plain token, extreme bytes,
    // cr lf pair, empty quoted token, empty lines, cr followed by cr
    dir_rows.push_back(data_row("a", 1'b0));
    dir_rows.push_back(data_row("b", 1'b0));
    dir_rows.push_back(typed_row(CH_TAB, 1,
      mk_result(KIND_TOKEN, 16'd0, 16'd2, 14'd0, 1'b0, 32'd1, NO_STATUS, 1'b1), NO_RESULT));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row(CH_BSLASH, 1'b0));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row("c", 1'b0));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row(8'hFF, 1'b0));
    dir_rows.push_back(data_row(8'h00, 1'b0));
    dir_rows.push_back(typed_row(CH_CR, 2,
      mk_result(KIND_TOKEN, 16'd7, 16'd4, 14'd2, 1'b0, 32'd1, NO_STATUS, 1'b0),
      mk_result(KIND_LINE, 16'd0, 16'd0, 14'd3, 1'b0, 32'd1, NO_STATUS, 1'b1)));
    dir_rows.push_back(typed_row(CH_LF, 0, NO_RESULT, NO_RESULT));
    dir_rows.push_back(data_row(CH_SPACE, 1'b0));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(data_row(CH_LF, 1'b0));
    dir_rows.push_back(data_row(CH_CR, 1'b0));
    dir_rows.push_back(typed_row(CH_CR, 1,
      mk_result(KIND_LINE, 16'd0, 16'd0, 14'd0, 1'b0, 32'd4, NO_STATUS, 1'b1), NO_RESULT));
    dir_rows.push_back(data_row("x", 1'b0));
    dir_rows.push_back(data_row(CH_LF, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k])
      send_item(dir_rows[k]);
    wait_for_results();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          len_cfg = 16'd2;
          tok_cfg = 14'd1;
        end
        1: begin
          len_cfg = 16'hFFFF;
          tok_cfg = 14'h3FFF;
        end
        2: begin
          len_cfg = 16'($urandom_range(3, 20));
          tok_cfg = 14'($urandom_range(1, 4));
        end
        3: begin
          len_cfg = 16'($urandom_range(8, 300));
          tok_cfg = 14'($urandom_range(1, 16));
        end
        default: begin
          len_cfg = MAX_LINE_LENGTH_RST;
          tok_cfg = MAX_TOKENS_RST;
        end
      endcase
      write_reg(REG_MAX_LINE_LENGTH, len_cfg);
      write_reg(REG_MAX_TOKENS, {2'($urandom_range(0, 3)), tok_cfg});
      sent = 0;
      while (sent < 100) begin
        build_line();
        foreach (line_q[k])
          send_item(data_row(line_q[k], 1'b0));
        sent += line_q.size();
      end
      wait_for_results();
    end

    // the block stops for good on its first status, so one ending per run
    ending = 3'($urandom_range(0, 4));
    case (ending)
      ST_EOF: begin
        if ($urandom_range(0, 1)) begin
          send_item(data_row("x", 1'b0));
          send_item(data_row(CH_CR, 1'b0));
        end
        send_item(data_row(8'($urandom_range(0, 255)), 1'b1));
      end
      ST_INCOMPLETE: begin
        case ($urandom_range(0, 2))
          0: send_item(data_row(CH_SPACE, 1'b0));
          1: begin
            send_item(data_row("a", 1'b0));
            send_item(data_row("b", 1'b0));
          end
          default: begin
            send_item(data_row(CH_QUOTE, 1'b0));
            send_item(data_row("b", 1'b0));
          end
        endcase
        send_item(data_row(8'($urandom_range(0, 255)), 1'b1));
      end
      ST_UNMATCHED: begin
        send_item(data_row(CH_QUOTE, 1'b0));
        send_item(data_row("z", 1'b0));
        send_item(data_row($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0));
      end
      ST_TOO_LONG: begin
        write_reg(REG_MAX_LINE_LENGTH, 16'($urandom_range(2, 12)));
        repeat (model.lim_len + 1)
          send_item(data_row("y", 1'b0));
      end
      ST_TOO_MANY: begin
        write_reg(REG_MAX_LINE_LENGTH, 16'hFFFF);
        write_reg(REG_MAX_TOKENS, 16'($urandom_range(1, 4)));
        repeat (model.lim_tok) begin
          send_item(data_row("a", 1'b0));
          send_item(data_row(CH_SPACE, 1'b0));
        end
        case ($urandom_range(0, 2))
          0: begin
            send_item(data_row("a", 1'b0));
            send_item(data_row(CH_TAB, 1'b0));
          end
          1: begin
            send_item(data_row("a", 1'b0));
            send_item(data_row(CH_LF, 1'b0));
          end
          default: begin
            send_item(data_row(CH_QUOTE, 1'b0));
            send_item(data_row("a", 1'b0));
            send_item(data_row(CH_QUOTE, 1'b0));
          end
        endcase
      end
      default: send_item(data_row(8'($urandom_range(0, 255)), 1'b1));
    endcase
    // stopped: these must be swallowed without any result
    repeat (4)
      send_item(data_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    wait_for_results();

    if (pending_results.size() != 0) begin
      mismatches++;
      $error("%0d expected result transactions never arrived", pending_results.size());
    end
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
